[sv/cfpsu_pkg.sv]
// Shared constants, types and stage offsets for the central-force particle step unit.
// No dependencies; every other file refers to it by scoped names.
package cfpsu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DIV_SH     = 4 * FRAC_BITS - 30;
    localparam int DT_W       = 17;
    localparam int MASS_W     = 31;
    localparam int DEN_W      = 127;
    localparam int REM_W      = 128;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    localparam int LAT_SA = 2;
    localparam int LAT_SQ = SQRT_STEPS + 2;
    localparam int LAT_CU = 5;
    localparam int LAT_DV = DIV_STEPS + 2;

    // stage at which each unit takes its operands
    localparam int S_SQ  = LAT_SA;
    localparam int S_CU  = S_SQ + LAT_SQ;
    localparam int S_DV  = S_CU + LAT_CU;
    localparam int S_KK  = S_DV + LAT_DV;
    localparam int S_D2  = S_KK + LAT_SA;
    localparam int S_OUT = S_D2 + LAT_SA;
    localparam int LAT   = S_OUT + 1;

    localparam logic [DT_W-1:0] DT_RESET = DT_W'(66);

    typedef enum logic [0:0] {
        CFG_STEP_LENGTH     = 1'b0,
        CFG_INTEGRATOR_MODE = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        MODE_LEAPFROG = 1'b0,
        MODE_EULER    = 1'b1
    } t_mode;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic [MASS_W-1:0]  mass;
        logic               sing;
    } t_side;

endpackage

[sv/cfpsu_scale_add.sv]
// Two-stage saturating add of a rounded scaled product: base + round(mul * dt / 2^s).
// Uses cfpsu_pkg for the fraction width and the step-length width.
module cfpsu_scale_add (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [31:0]            i_base,
    input  logic signed [31:0]            i_mul,
    input  logic [cfpsu_pkg::DT_W-1:0]    i_dt,
    input  logic                          i_half,
    output logic signed [31:0]            o_sum
);
    localparam logic signed [51:0] SAT_HI = 52'sd2147483647;
    localparam logic signed [51:0] SAT_LO = -52'sd2147483648;

    logic signed [49:0] r_prod;
    logic signed [31:0] r_base;
    logic               r_half;
    logic signed [31:0] r_sum;
    logic signed [50:0] w_rnd;
    logic signed [50:0] w_shift;
    logic signed [51:0] w_total;
    logic signed [31:0] n_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_mul * $signed({1'b0, i_dt});
            r_base <= i_base;
            r_half <= i_half;
            r_sum  <= n_sum;
        end
    end

    always_comb begin
        w_rnd   = {r_prod[49], r_prod} + (r_half ? (51'sd1 <<< cfpsu_pkg::FRAC_BITS)
                                                 : (51'sd1 <<< (cfpsu_pkg::FRAC_BITS - 1)));
        w_shift = r_half ? (w_rnd >>> (cfpsu_pkg::FRAC_BITS + 1))
                         : (w_rnd >>> cfpsu_pkg::FRAC_BITS);
        w_total = {{20{r_base[31]}}, r_base} + {w_shift[50], w_shift};
        if (w_total > SAT_HI) begin
            n_sum = 32'sh7FFFFFFF;
        end else if (w_total < SAT_LO) begin
            n_sum = 32'sh80000000;
        end else begin
            n_sum = w_total[31:0];
        end
    end

    assign o_sum = r_sum;

endmodule

[sv/cfpsu_sqrt.sv]
// Pipelined integer square root of x^2 + y^2, one result bit per stage.
// Uses cfpsu_pkg for the step count.
module cfpsu_sqrt (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    output logic [31:0]        o_root
);
    localparam int N = cfpsu_pkg::SQRT_STEPS;

    logic [31:0] w_ux;
    logic [31:0] w_uy;
    logic [63:0] r_sx;
    logic [63:0] r_sy;
    logic [63:0] r_n   [0:N];
    logic [63:0] r_res [0:N];

    assign w_ux = i_pos_x[31] ? 32'(-i_pos_x) : i_pos_x;
    assign w_uy = i_pos_y[31] ? 32'(-i_pos_y) : i_pos_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx     <= w_ux * w_ux;
            r_sy     <= w_uy * w_uy;
            r_n[0]   <= r_sx + r_sy;
            r_res[0] <= '0;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] w_trial;
        logic        w_ge;
        assign w_trial = r_res[k] + BIT;
        assign w_ge    = r_n[k] >= w_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k+1]   <= w_ge ? r_n[k] - w_trial : r_n[k];
                r_res[k+1] <= w_ge ? (r_res[k] >> 1) + BIT : r_res[k] >> 1;
            end
        end
    end

    assign o_root = r_res[N][31:0];

endmodule

[sv/cfpsu_cube.sv]
// Divisor build: R^3 * M from 32x32 partial products over five stages.
// Uses cfpsu_pkg for widths.
module cfpsu_cube (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [31:0]                       i_root,
    input  logic [cfpsu_pkg::MASS_W-1:0]      i_mass,
    output logic [cfpsu_pkg::DEN_W-1:0]       o_den
);
    localparam int MW = cfpsu_pkg::MASS_W;
    localparam int DW = cfpsu_pkg::DEN_W;

    logic [63:0]    r_r2;
    logic [31:0]    r_r1;
    logic [MW-1:0]  r_m1;
    logic [63:0]    r_pl;
    logic [63:0]    r_ph;
    logic [MW-1:0]  r_m2;
    logic [95:0]    r_r3;
    logic [MW-1:0]  r_m3;
    logic [62:0]    r_q0;
    logic [62:0]    r_q1;
    logic [62:0]    r_q2;
    logic [DW-1:0]  r_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r2  <= i_root * i_root;
            r_r1  <= i_root;
            r_m1  <= i_mass;
            r_pl  <= r_r2[31:0] * r_r1;
            r_ph  <= r_r2[63:32] * r_r1;
            r_m2  <= r_m1;
            r_r3  <= 96'(r_pl) + (96'(r_ph) << 32);
            r_m3  <= r_m2;
            r_q0  <= r_r3[31:0] * r_m3;
            r_q1  <= r_r3[63:32] * r_m3;
            r_q2  <= r_r3[95:64] * r_m3;
            r_den <= DW'(r_q0) + (DW'(r_q1) << 32) + (DW'(r_q2) << 64);
        end
    end

    assign o_den = r_den;

endmodule

[sv/cfpsu_div.sv]
// Pipelined restoring divider for one acceleration component, with rounding,
// sign and saturation in the last stage. Uses cfpsu_pkg for widths and step count.
module cfpsu_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [31:0]           i_coord,
    input  logic [cfpsu_pkg::DEN_W-1:0]  i_den,
    output logic signed [31:0]           o_acc
);
    localparam int N  = cfpsu_pkg::DIV_STEPS;
    localparam int RW = cfpsu_pkg::REM_W;
    localparam int DW = cfpsu_pkg::DEN_W;

    logic [31:0]    w_mag;
    logic [RW-1:0]  w_num;
    logic [RW-1:0]  r_rem [0:N];
    logic [DW-1:0]  r_den [0:N];
    logic [31:0]    r_q   [0:N];
    logic           r_ovf [0:N];
    logic           r_pos [0:N];
    logic           r_neg [0:N];
    logic [32:0]    w_mq;
    logic signed [31:0] n_acc;
    logic signed [31:0] r_acc;

    assign w_mag = i_coord[31] ? 32'(-i_coord) : i_coord;
    assign w_num = RW'(w_mag) << cfpsu_pkg::DIV_SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= w_num >= RW'(i_den);
            r_pos[0] <= !i_coord[31] && (i_coord != 32'sd0);
            r_neg[0] <= i_coord[31];
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [RW-1:0] w_t;
        logic          w_ge;
        assign w_t  = {r_rem[k][RW-2:0], 1'b0};
        assign w_ge = w_t >= RW'(r_den[k]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_ge ? w_t - RW'(r_den[k]) : w_t;
                r_den[k+1] <= r_den[k];
                r_q[k+1]   <= {r_q[k][30:0], w_ge};
                r_ovf[k+1] <= r_ovf[k];
                r_pos[k+1] <= r_pos[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    always_comb begin
        w_mq = r_ovf[N] ? 33'd2147483648 : (({1'b0, r_q[N]} + 33'd1) >> 1);
        if (r_pos[N]) begin
            n_acc = 32'(-w_mq);
        end else if (r_neg[N]) begin
            n_acc = (w_mq > 33'd2147483647) ? 32'sh7FFFFFFF : w_mq[31:0];
        end else begin
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

[sv/central_force_particle_step_unit.sv]
// Central-force particle step unit: one leapfrog or semi-implicit Euler step per particle.
// Input channel: i_valid with particle state, o_stall back. Output channel: o_valid with
// new state, acceleration and singular flag, i_stall back. A transaction moves at a clock
// edge where valid is high and stall is low.
// Throughput: one transaction per cycle while the receiver does not stall. The pipeline
// runs through the first drift, the 32-step square root, the divisor build, the 32-step
// divider, the kick and the second drift stages into the output register.
// The whole pipeline advances together; when the output holds a transaction and the
// receiver stalls, every stage holds and o_stall is raised. Bubbles travel with the data.
// Configuration (step length, integrator mode) goes through i_cfg_wr_en; the user must
// write it only while the pipeline is empty, not enforced by the block. Synchronous reset
// clears all valid bits, sets step length 66, leapfrog mode; no clearing pass is needed.
// Depends on cfpsu_pkg, cfpsu_scale_add, cfpsu_sqrt, cfpsu_cube and cfpsu_div.
module central_force_particle_step_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [0:0]                       i_cfg_index,
    input  logic [cfpsu_pkg::DT_W-1:0]       i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [31:0]               i_pos_x,
    input  logic signed [31:0]               i_pos_y,
    input  logic signed [31:0]               i_vel_x,
    input  logic signed [31:0]               i_vel_y,
    input  logic [cfpsu_pkg::MASS_W-1:0]     i_mass,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [31:0]               o_new_pos_x,
    output logic signed [31:0]               o_new_pos_y,
    output logic signed [31:0]               o_new_vel_x,
    output logic signed [31:0]               o_new_vel_y,
    output logic signed [31:0]               o_acc_x,
    output logic signed [31:0]               o_acc_y,
    output logic                             o_singular
);
    localparam int L  = cfpsu_pkg::LAT;
    localparam int SO = cfpsu_pkg::S_OUT;

    logic [cfpsu_pkg::DT_W-1:0]  r_dt;
    cfpsu_pkg::t_mode            r_mode;
    logic [1:L]                  r_vld;
    logic                        w_adv;
    cfpsu_pkg::t_side            r_side [1:SO];
    cfpsu_pkg::t_side            n_side [1:SO];

    logic signed [31:0] w_d1_x, w_d1_y;
    logic [31:0]        w_root;
    logic [cfpsu_pkg::DEN_W-1:0] w_den;
    logic signed [31:0] w_div_x, w_div_y;
    logic signed [31:0] w_acc_x, w_acc_y;
    logic signed [31:0] w_kick_x, w_kick_y;
    logic signed [31:0] w_d2_x, w_d2_y;

    logic signed [31:0] r_out_pos_x, r_out_pos_y, r_out_vel_x, r_out_vel_y;
    logic signed [31:0] r_out_acc_x, r_out_acc_y;
    logic               r_out_sing;

    assign w_adv   = !r_vld[L] || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_vld[L];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt   <= cfpsu_pkg::DT_RESET;
            r_mode <= cfpsu_pkg::MODE_LEAPFROG;
        end else if (i_cfg_wr_en) begin
            unique case (cfpsu_pkg::t_cfg_idx'(i_cfg_index))
                cfpsu_pkg::CFG_STEP_LENGTH: begin
                    r_dt <= i_cfg_data;
                end
                cfpsu_pkg::CFG_INTEGRATOR_MODE: begin
                    r_mode <= cfpsu_pkg::t_mode'(i_cfg_data[0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {i_valid, r_vld[1:L-1]};
        end
    end

    // side data carried alongside the arithmetic units
    always_comb begin
        n_side[1].pos_x = i_pos_x;
        n_side[1].pos_y = i_pos_y;
        n_side[1].vel_x = i_vel_x;
        n_side[1].vel_y = i_vel_y;
        n_side[1].acc_x = '0;
        n_side[1].acc_y = '0;
        n_side[1].mass  = i_mass;
        n_side[1].sing  = 1'b0;
        for (int k = 2; k <= SO; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[cfpsu_pkg::S_SQ+1].pos_x = w_d1_x;
        n_side[cfpsu_pkg::S_SQ+1].pos_y = w_d1_y;
        n_side[cfpsu_pkg::S_CU+1].sing  = (w_root == 32'd0) ||
                                          (r_side[cfpsu_pkg::S_CU].mass == '0);
        n_side[cfpsu_pkg::S_KK+1].acc_x = w_acc_x;
        n_side[cfpsu_pkg::S_KK+1].acc_y = w_acc_y;
        n_side[cfpsu_pkg::S_D2+1].vel_x = w_kick_x;
        n_side[cfpsu_pkg::S_D2+1].vel_y = w_kick_y;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side <= n_side;
        end
    end

    cfpsu_scale_add u_drift1_x (
        .i_clk(i_clk), .i_en(w_adv), .i_base(i_pos_x), .i_mul(i_vel_x), .i_dt(r_dt),
        .i_half(r_mode == cfpsu_pkg::MODE_LEAPFROG), .o_sum(w_d1_x)
    );
    cfpsu_scale_add u_drift1_y (
        .i_clk(i_clk), .i_en(w_adv), .i_base(i_pos_y), .i_mul(i_vel_y), .i_dt(r_dt),
        .i_half(r_mode == cfpsu_pkg::MODE_LEAPFROG), .o_sum(w_d1_y)
    );

    cfpsu_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(w_adv), .i_pos_x(w_d1_x), .i_pos_y(w_d1_y), .o_root(w_root)
    );

    cfpsu_cube u_cube (
        .i_clk(i_clk), .i_en(w_adv), .i_root(w_root),
        .i_mass(r_side[cfpsu_pkg::S_CU].mass), .o_den(w_den)
    );

    cfpsu_div u_div_x (
        .i_clk(i_clk), .i_en(w_adv), .i_coord(r_side[cfpsu_pkg::S_DV].pos_x),
        .i_den(w_den), .o_acc(w_div_x)
    );
    cfpsu_div u_div_y (
        .i_clk(i_clk), .i_en(w_adv), .i_coord(r_side[cfpsu_pkg::S_DV].pos_y),
        .i_den(w_den), .o_acc(w_div_y)
    );

    assign w_acc_x = r_side[cfpsu_pkg::S_KK].sing ? 32'sd0 : w_div_x;
    assign w_acc_y = r_side[cfpsu_pkg::S_KK].sing ? 32'sd0 : w_div_y;

    cfpsu_scale_add u_kick_x (
        .i_clk(i_clk), .i_en(w_adv), .i_base(r_side[cfpsu_pkg::S_KK].vel_x),
        .i_mul(w_acc_x), .i_dt(r_dt), .i_half(1'b0), .o_sum(w_kick_x)
    );
    cfpsu_scale_add u_kick_y (
        .i_clk(i_clk), .i_en(w_adv), .i_base(r_side[cfpsu_pkg::S_KK].vel_y),
        .i_mul(w_acc_y), .i_dt(r_dt), .i_half(1'b0), .o_sum(w_kick_y)
    );

    cfpsu_scale_add u_drift2_x (
        .i_clk(i_clk), .i_en(w_adv), .i_base(r_side[cfpsu_pkg::S_D2].pos_x),
        .i_mul(w_kick_x), .i_dt(r_dt), .i_half(1'b1), .o_sum(w_d2_x)
    );
    cfpsu_scale_add u_drift2_y (
        .i_clk(i_clk), .i_en(w_adv), .i_base(r_side[cfpsu_pkg::S_D2].pos_y),
        .i_mul(w_kick_y), .i_dt(r_dt), .i_half(1'b1), .o_sum(w_d2_y)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pos_x <= (r_mode == cfpsu_pkg::MODE_EULER) ? r_side[SO].pos_x : w_d2_x;
            r_out_pos_y <= (r_mode == cfpsu_pkg::MODE_EULER) ? r_side[SO].pos_y : w_d2_y;
            r_out_vel_x <= r_side[SO].vel_x;
            r_out_vel_y <= r_side[SO].vel_y;
            r_out_acc_x <= r_side[SO].acc_x;
            r_out_acc_y <= r_side[SO].acc_y;
            r_out_sing  <= r_side[SO].sing;
        end
    end

    assign o_new_pos_x = r_out_pos_x;
    assign o_new_pos_y = r_out_pos_y;
    assign o_new_vel_x = r_out_vel_x;
    assign o_new_vel_y = r_out_vel_y;
    assign o_acc_x     = r_out_acc_x;
    assign o_acc_y     = r_out_acc_y;
    assign o_singular  = r_out_sing;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_sing_zero_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> (o_acc_x == 32'sd0) && (o_acc_y == 32'sd0))
        else $error("singular transaction with nonzero acceleration");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (r_vld == $past(r_vld)))
        else $error("pipeline moved while stalled");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_vld[L-1]))
        else $error("output valid without a transaction in the last stage");

endmodule
